>>> hdl/hes_pkg.sv
// Package for the HTML escape stream core: widths, register and status codes,
// the result-run type and the escape expansion function.
// Depends on nothing; every other file in hdl uses it.
package hes_pkg;

  localparam int BYTE_W        = 8;
  localparam int MODE_W        = 2;
  localparam int CAP_W         = 16;
  localparam int STATUS_W      = 2;
  localparam int MAX_RUN       = 6;
  localparam int CNT_W         = 3;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int LEN_WIDTH_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_TEXT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ATTR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_JS   = 2'd2;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd4096;

  localparam logic REG_ESCAPE_MODE = 1'b0;
  localparam logic REG_CAPACITY    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DATA     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
  localparam logic [BYTE_W-1:0] CH_LT   = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT   = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_QUOT = 8'h22;
  localparam logic [BYTE_W-1:0] CH_APOS = 8'h27;
  localparam logic [BYTE_W-1:0] CH_BSL  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;

  typedef struct packed {
    logic [MODE_W-1:0] escape_mode;
    logic [CAP_W-1:0]  capacity;
  } cfg_t;

  // Byte 0 of seq is emitted first.
  typedef struct packed {
    logic [0:MAX_RUN-1][BYTE_W-1:0] seq;
    logic [CNT_W-1:0]               len;
  } run_t;

  typedef struct packed {
    logic                valid;
    run_t                run;
    logic [STATUS_W-1:0] status;
  } load_t;

  function automatic run_t expand(input logic [BYTE_W-1:0] b, input logic [MODE_W-1:0] mode);
    run_t r;
    logic attr;
    logic js;
    attr = (mode == MODE_ATTR) || (mode == MODE_JS);
    js = (mode == MODE_JS);
    r.seq = '0;
    r.seq[0] = b;
    r.len = 3'd1;
    if (b == CH_AMP) begin
      r.seq = {"&amp;", 8'h00};
      r.len = 3'd5;
    end else if (b == CH_LT) begin
      r.seq = {"&lt;", 16'h0000};
      r.len = 3'd4;
    end else if (b == CH_GT) begin
      r.seq = {"&gt;", 16'h0000};
      r.len = 3'd4;
    end else if (attr && b == CH_QUOT) begin
      r.seq = {"&quot;"};
      r.len = 3'd6;
    end else if (js && b == CH_APOS) begin
      r.seq = {"\\&#39;"};
      r.len = 3'd6;
    end else if (attr && b == CH_APOS) begin
      r.seq = {"&#39;", 8'h00};
      r.len = 3'd5;
    end else if (js && b == CH_BSL) begin
      r.seq = {"\\\\", 32'h0000_0000};
      r.len = 3'd2;
    end else if (js && b == CH_LF) begin
      r.seq = {"\\n", 32'h0000_0000};
      r.len = 3'd2;
    end else if (js && b == CH_CR) begin
      r.seq = {"\\r", 32'h0000_0000};
      r.len = 3'd2;
    end
    return r;
  endfunction

endpackage

>>> hdl/hes_cfg.sv
// Configuration register file of the HTML escape stream core behind an
// APB-style port. Depends on hes_pkg.
module hes_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hes_pkg::ADDR_W-1:0]  paddr,
  input  logic [hes_pkg::DATA_W-1:0]  pwdata,
  output logic [hes_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output hes_pkg::cfg_t               cfg
);

  logic [hes_pkg::MODE_W-1:0] escape_mode;
  logic [hes_pkg::CAP_W-1:0]  capacity;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= hes_pkg::MODE_TEXT;
      capacity    <= hes_pkg::CAPACITY_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        hes_pkg::REG_ESCAPE_MODE: escape_mode <= pwdata[hes_pkg::MODE_W-1:0];
        hes_pkg::REG_CAPACITY:    capacity    <= pwdata[hes_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      hes_pkg::REG_ESCAPE_MODE:
        prdata = {{(hes_pkg::DATA_W-hes_pkg::MODE_W){1'b0}}, escape_mode};
      hes_pkg::REG_CAPACITY:
        prdata = {{(hes_pkg::DATA_W-hes_pkg::CAP_W){1'b0}}, capacity};
      default: prdata = '0;
    endcase
  end

  assign cfg.escape_mode = escape_mode;
  assign cfg.capacity    = capacity;

endmodule

>>> hdl/hes_engine.sv
// Input register, string length and overflow tracking, and escape expansion
// of the HTML escape stream core. Depends on hes_pkg.
module hes_engine #(
  parameter int LEN_WIDTH = hes_pkg::LEN_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hes_pkg::BYTE_W-1:0]  ch,
  input  hes_pkg::cfg_t               cfg,
  input  logic                        run_free,
  output hes_pkg::load_t              load
);

  localparam int TOT_W = LEN_WIDTH + 1;
  localparam int CMP_W = (TOT_W > hes_pkg::CAP_W) ? TOT_W : hes_pkg::CAP_W;

  logic                       s1_valid;
  logic [hes_pkg::BYTE_W-1:0] s1_ch;
  logic [LEN_WIDTH-1:0]       out_length;
  logic [LEN_WIDTH-1:0]       out_length_next;
  logic                       failed;
  logic                       failed_next;
  hes_pkg::run_t              run;
  logic [TOT_W-1:0]           total;
  logic                       is_end;
  logic                       fits;
  logic                       emits;
  logic                       advance;
  logic                       cap_zero;

  assign run      = hes_pkg::expand(s1_ch, cfg.escape_mode);
  assign total    = {1'b0, out_length} + TOT_W'(run.len);
  assign cap_zero = (cfg.capacity == '0);
  assign is_end   = (s1_ch == hes_pkg::CH_NUL);
  assign fits     = !total[LEN_WIDTH] && (CMP_W'(total) < CMP_W'(cfg.capacity));
  assign emits    = is_end || (!failed && !cap_zero && fits);
  assign advance  = s1_valid && (!emits || run_free);
  assign in_stall = s1_valid && !advance;

  always_comb begin
    out_length_next = out_length;
    failed_next     = failed;
    if (is_end) begin
      out_length_next = '0;
      failed_next     = 1'b0;
    end else if (!failed) begin
      if (!cap_zero && fits) begin
        out_length_next = total[LEN_WIDTH-1:0];
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  always_comb begin
    load.valid  = advance && emits;
    load.run    = run;
    load.status = hes_pkg::STATUS_DATA;
    if (is_end) begin
      load.run.seq = '0;
      load.run.len = 3'd1;
      load.status  = (failed || cap_zero) ? hes_pkg::STATUS_OVERFLOW : hes_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_length <= '0;
      failed     <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_length <= out_length_next;
        failed     <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ch <= ch;
    end
  end

endmodule

>>> hdl/hes_serial.sv
// Result register of the HTML escape stream core: holds one escaped run and
// sends it out one byte per transaction. Depends on hes_pkg.
module hes_serial (
  input  logic                          clk,
  input  logic                          rst,
  input  hes_pkg::load_t                load,
  output logic                          run_free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hes_pkg::BYTE_W-1:0]    out_byte,
  output logic                          run_last,
  output logic [hes_pkg::STATUS_W-1:0]  status
);

  logic                                        rb_valid;
  logic [0:hes_pkg::MAX_RUN-1][hes_pkg::BYTE_W-1:0] rb_seq;
  logic [hes_pkg::CNT_W-1:0]                   rb_len;
  logic [hes_pkg::CNT_W-1:0]                   rb_idx;
  logic [hes_pkg::STATUS_W-1:0]                rb_status;
  logic                                        last;
  logic                                        out_acc;

  assign last     = (rb_idx == rb_len - 3'd1);
  assign out_acc  = rb_valid && !out_stall;
  assign run_free = !rb_valid || (out_acc && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_valid <= 1'b0;
      rb_idx   <= '0;
    end else if (load.valid) begin
      rb_valid <= 1'b1;
      rb_idx   <= '0;
    end else if (out_acc) begin
      if (last) begin
        rb_valid <= 1'b0;
      end else begin
        rb_idx <= rb_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      rb_seq    <= load.run.seq;
      rb_len    <= load.run.len;
      rb_status <= load.status;
    end
  end

  assign out_valid = rb_valid;
  assign out_byte  = rb_seq[rb_idx];
  assign run_last  = last;
  assign status    = rb_status;

endmodule

>>> hdl/html_escape_stream_core.sv
// Top level of the HTML escape stream core: configuration port, expansion
// engine and result serializer. Depends on hes_pkg, hes_cfg, hes_engine, hes_serial.
//
// Usage: source bytes enter on the input channel (in_valid, in_stall, ch), one
// per transaction. Each byte leaves as its escaped form on the output channel
// (out_valid, out_stall, out_byte, run_last, status), one byte per transaction,
// with run_last set on the final byte of each run. A zero byte ends the string
// and yields one status transaction (ok or overflow) with out_byte zero.
// Bytes that do not fit in the capacity, and all later bytes of a failed
// string, yield nothing.
// An accepted byte passes the input register, then the result register, to the output.
// Plain text streams at one byte per cycle while the receiver does not stall;
// an escaped byte occupies the result register until all bytes of its
// replacement (up to six) have left, as the output carries one byte per
// transaction.
// Reset clears the string length and failure flag, sets escape_mode to text
// and capacity to 4096, and empties both stages. When the receiver stalls the
// result holds; the input register can still take one byte, and in_stall stays
// high while a byte that yields output waits there for the result register.
// Write the configuration registers only while the block is idle.
module html_escape_stream_core #(
  parameter int LEN_WIDTH = hes_pkg::LEN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hes_pkg::ADDR_W-1:0]    paddr,
  input  logic [hes_pkg::DATA_W-1:0]    pwdata,
  output logic [hes_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hes_pkg::BYTE_W-1:0]    ch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hes_pkg::BYTE_W-1:0]    out_byte,
  output logic                          run_last,
  output logic [hes_pkg::STATUS_W-1:0]  status
);

  hes_pkg::cfg_t  cfg;
  hes_pkg::load_t load;
  logic           run_free;

  hes_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hes_engine #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .cfg      (cfg),
    .run_free (run_free),
    .load     (load)
  );

  hes_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .run_free  (run_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .status    (status)
  );

endmodule

>>> hdl/hes_checker.sv
// Port-level checker for the HTML escape stream core, bound to the top level.
// Depends on hes_pkg and html_escape_stream_core.
module hes_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hes_pkg::BYTE_W-1:0]    out_byte,
  input logic                          run_last,
  input logic [hes_pkg::STATUS_W-1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(status))
    else $error("output transaction changed while stalled");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != hes_pkg::STATUS_DATA |-> run_last && out_byte == '0)
    else $error("status transaction is not a single zero byte");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == hes_pkg::STATUS_DATA || status == hes_pkg::STATUS_OK
      || status == hes_pkg::STATUS_OVERFLOW)
    else $error("undefined status code");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid && status == hes_pkg::STATUS_DATA)
    else $error("escaped run broken off before its last byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind html_escape_stream_core hes_checker u_hes_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .run_last  (run_last),
  .status    (status)
);

>>> dv/hes_escape_checker.sv
// Scoreboard for the HTML escape stream core: follows the register writes and
// both channels, predicts every escaped run and compares it with the output.
// Depends on hes_pkg.
`timescale 1ns / 1ps

module hes_escape_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [hes_pkg::ADDR_W-1:0]   paddr,
  input  logic [hes_pkg::DATA_W-1:0]   pwdata,
  input  logic                   pready,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [hes_pkg::BYTE_W-1:0]   ch,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [hes_pkg::BYTE_W-1:0]   out_byte,
  input  logic                   run_last,
  input  logic [hes_pkg::STATUS_W-1:0] status,
  output int                     fail_count,
  output int                     pending
);

  localparam int LEN_LIMIT = (1 << hes_pkg::LEN_WIDTH_DEF) - 1;

  typedef struct packed {
    logic [hes_pkg::BYTE_W-1:0]   b;
    logic                         last;
    logic [hes_pkg::STATUS_W-1:0] st;
  } esc_beat_t;

  esc_beat_t                  expected_q[$];
  logic [hes_pkg::MODE_W-1:0] mode_q;
  logic [hes_pkg::CAP_W-1:0]  cap_q;
  int                         str_len;
  logic                       str_failed;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    // Printing stops after 40 mismatches so a broken design cannot flood the log.
    if (fail_count < 40) $display("%0t ns: %s", $time, what);
    fail_count++;
  endtask

  function automatic string entity_for(input logic [hes_pkg::BYTE_W-1:0] b,
                                       input logic [hes_pkg::MODE_W-1:0] m);
    logic attr;
    logic js;
    attr = (m == hes_pkg::MODE_ATTR) || (m == hes_pkg::MODE_JS);
    js = (m == hes_pkg::MODE_JS);
    if (b == hes_pkg::CH_AMP) return "&amp;";
    if (b == hes_pkg::CH_LT) return "&lt;";
    if (b == hes_pkg::CH_GT) return "&gt;";
    if (attr && b == hes_pkg::CH_QUOT) return "&quot;";
    if (js && b == hes_pkg::CH_APOS) return "\\&#39;";
    if (attr && b == hes_pkg::CH_APOS) return "&#39;";
    if (js && b == hes_pkg::CH_BSL) return "\\\\";
    if (js && b == hes_pkg::CH_LF) return "\\n";
    if (js && b == hes_pkg::CH_CR) return "\\r";
    return "";
  endfunction

  task automatic predict_escape(input logic [hes_pkg::BYTE_W-1:0] b);
    string     rep;
    int        n;
    int        total;
    esc_beat_t beat;
    if (b == hes_pkg::CH_NUL) begin
      beat.b = hes_pkg::CH_NUL;
      beat.last = 1'b1;
      beat.st = (str_failed || cap_q == 0) ? hes_pkg::STATUS_OVERFLOW : hes_pkg::STATUS_OK;
      expected_q.push_back(beat);
      str_len = 0;
      str_failed = 1'b0;
    end else if (!str_failed) begin
      if (cap_q == 0) begin
        str_failed = 1'b1;
      end else begin
        rep = entity_for(b, mode_q);
        n = (rep.len() == 0) ? 1 : rep.len();
        total = str_len + n;
        if (total >= int'(cap_q) || total > LEN_LIMIT) begin
          str_failed = 1'b1;
        end else begin
          for (int k = 0; k < n; k++) begin
            beat.b = (rep.len() == 0) ? b : rep[k];
            beat.last = (k == n - 1);
            beat.st = hes_pkg::STATUS_DATA;
            expected_q.push_back(beat);
          end
          str_len = total;
        end
      end
    end
  endtask

  task automatic check_beat();
    esc_beat_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: byte %02h run_last %0d status %0d",
                                out_byte, run_last, status));
    end else begin
      want = expected_q.pop_front();
      if (out_byte !== want.b)
        report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.b));
      if (run_last !== want.last)
        report_mismatch($sformatf("run_last %0d, expected %0d", run_last, want.last));
      if (status !== want.st)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      mode_q = hes_pkg::MODE_TEXT;
      cap_q = hes_pkg::CAPACITY_RESET;
      str_len = 0;
      str_failed = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {hes_pkg::REG_ESCAPE_MODE, 2'b00}) begin
          mode_q = pwdata[hes_pkg::MODE_W-1:0];
        end else if (paddr == {hes_pkg::REG_CAPACITY, 2'b00}) begin
          cap_q = pwdata[hes_pkg::CAP_W-1:0];
        end
      end
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) predict_escape(ch);
    end
    pending = expected_q.size();
  end

endmodule

>>> dv/tb_html_escape_stream_core.sv
// Testbench top for the HTML escape stream core: clock, reset, register writes,
// source strings and output stalls, plus the final verdict.
// Depends on hes_pkg, html_escape_stream_core and hes_escape_checker.
`timescale 1ns / 1ps

module tb_html_escape_stream_core;

  localparam logic [hes_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_DRAIN} pressure_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [hes_pkg::ADDR_W-1:0]   paddr;
  logic [hes_pkg::DATA_W-1:0]   pwdata;
  logic [hes_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid;
  logic                         in_stall;
  logic [hes_pkg::BYTE_W-1:0]   ch;
  logic                         out_valid;
  logic                         out_stall;
  logic [hes_pkg::BYTE_W-1:0]   out_byte;
  logic                         run_last;
  logic [hes_pkg::STATUS_W-1:0] status;

  int fail_count;
  int pending;
  int stall_pct;
  int gap_max;
  int burst_left;
  int hold_left;
  int items_sent;
  bit long_hold_go;

  html_escape_stream_core dut (.*);

  hes_escape_checker escape_check (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .run_last(run_last), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_html_escape_stream_core NOT OK");
    $finish;
  end

  always @(negedge clk) begin
    if (long_hold_go) begin
      hold_left = 300;
      long_hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [hes_pkg::BYTE_W-1:0] random_char();
    logic [hes_pkg::BYTE_W-1:0] specials[8];
    logic [31:0]                pick;
    specials = '{hes_pkg::CH_AMP, hes_pkg::CH_LT, hes_pkg::CH_GT, hes_pkg::CH_QUOT,
                 hes_pkg::CH_APOS, hes_pkg::CH_BSL, hes_pkg::CH_LF, hes_pkg::CH_CR};
    if ($urandom_range(0, 99) < 40) return specials[$urandom_range(0, 7)];
    pick = $urandom_range(1, 255);
    return pick[hes_pkg::BYTE_W-1:0];
  endfunction

  task automatic send_item(input logic [hes_pkg::BYTE_W-1:0] b);
    logic [31:0] noise;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, gap_max)) begin
        @(negedge clk);
        in_valid <= 1'b0;
        noise = $urandom;
        ch <= noise[hes_pkg::BYTE_W-1:0];
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    ch <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Most strings are terminated; a few run on into the next one.
  task automatic send_string(input int max_len);
    repeat ($urandom_range(0, max_len)) send_item(random_char());
    if ($urandom_range(0, 9) != 0) send_item(hes_pkg::CH_NUL);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [hes_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [hes_pkg::MODE_W-1:0] mode,
                            input logic [hes_pkg::CAP_W-1:0] cap);
    settle();
    write_reg(hes_pkg::REG_ESCAPE_MODE, {{(hes_pkg::DATA_W-hes_pkg::MODE_W){1'b0}}, mode});
    write_reg(hes_pkg::REG_CAPACITY, {{(hes_pkg::DATA_W-hes_pkg::CAP_W){1'b0}}, cap});
  endtask

  task automatic run_phase(input logic [hes_pkg::MODE_W-1:0] mode, input int cap,
                           input int stall, input int gaps, input pressure_t press,
                           input int quota);
    int  start;
    bit  paused;
    set_config(mode, cap[hes_pkg::CAP_W-1:0]);
    stall_pct = stall;
    gap_max = gaps;
    start = items_sent;
    paused = 1'b0;
    if (press == PRESS_HOLD) long_hold_go = 1'b1;
    while (items_sent - start < quota) begin
      if (press == PRESS_DRAIN && !paused && items_sent - start >= quota / 2) begin
        settle();
        paused = 1'b1;
      end
      send_string(20);
    end
  endtask

  initial begin
    logic [hes_pkg::BYTE_W-1:0] pat[$];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    ch = '0;
    out_stall = 1'b0;
    stall_pct = 0;
    gap_max = 0;
    burst_left = 0;
    hold_left = 0;
    long_hold_go = 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    stall_pct = 25;
    gap_max = 3;
    set_config(hes_pkg::MODE_JS, 16'd4096);
    pat = {hes_pkg::CH_AMP, hes_pkg::CH_LT, hes_pkg::CH_GT, hes_pkg::CH_QUOT,
           hes_pkg::CH_APOS, hes_pkg::CH_BSL, hes_pkg::CH_LF, hes_pkg::CH_CR,
           8'hFF, 8'h01, hes_pkg::CH_NUL};
    foreach (pat[i]) send_item(pat[i]);
    set_config(hes_pkg::MODE_ATTR, 16'd7);
    pat = {hes_pkg::CH_QUOT, 8'h61, hes_pkg::CH_APOS, hes_pkg::CH_NUL};
    foreach (pat[i]) send_item(pat[i]);
    set_config(MODE_UNUSED, 16'hFFFF);
    pat = {hes_pkg::CH_APOS, hes_pkg::CH_AMP, hes_pkg::CH_NUL};
    foreach (pat[i]) send_item(pat[i]);
    set_config(hes_pkg::MODE_TEXT, 16'd0);
    pat = {8'h61, hes_pkg::CH_NUL, hes_pkg::CH_NUL};
    foreach (pat[i]) send_item(pat[i]);

    run_phase(hes_pkg::MODE_TEXT, 4096, 0, 0, PRESS_NONE, 60);
    run_phase(hes_pkg::MODE_ATTR, $urandom_range(1, 30), 30, 4, PRESS_NONE, 60);
    run_phase(hes_pkg::MODE_JS, 65535, 20, 2, PRESS_HOLD, 60);
    run_phase(hes_pkg::MODE_JS, $urandom_range(0, 40), 60, 8, PRESS_DRAIN, 60);
    run_phase(MODE_UNUSED, $urandom_range(5, 60), 10, 1, PRESS_NONE, 45);
    run_phase(hes_pkg::MODE_ATTR, 12, 40, 3, PRESS_NONE, 50);
    run_phase(hes_pkg::MODE_TEXT, $urandom_range(3, 25), 15, 5, PRESS_NONE, 50);

    settle();
    if (fail_count == 0) begin
      $display("tb_html_escape_stream_core OK");
    end else begin
      $display("tb_html_escape_stream_core NOT OK");
    end
    $finish;
  end

endmodule
